### rtl/tbht_pkg.sv
// ----------------------------------------------------------------------------
// tbht_pkg
// Shared types and codes for the touch button hit table.
// ----------------------------------------------------------------------------
package tbht_pkg;

    localparam int CMD_W     = 3;
    localparam int SLOT_W    = 4;
    localparam int M_TDATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ENABLE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TOUCH   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_ALL = 3'd5;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_MISS = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic exec_op;
        logic scan_start;
        logic scan_run;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_touch;
        logic scan_done;
        logic out_free;
    } ctrl_stat_t;

endpackage

### rtl/touch_button_hit_table_core.sv
// ----------------------------------------------------------------------------
// touch_button_hit_table_core
// Rectangle hit-test table with add, delete, enable, disable, touch, delete all.
// ----------------------------------------------------------------------------
// Commands other than touch go from idle through the execute and output states.
// Touch scans one slot per cycle through the single rectangle memory read port:
//   the scan stops at the first enabled hit, or after the last slot on a miss.
// One transaction at a time; the next is accepted once the result is loaded into the
//   output register, and a stalled output holds off the next acceptance.
// Reset (synchronous, aresetn low) clears used and enabled flags; rectangle
//   entries stay undefined until written by add.
module touch_button_hit_table_core #(
    parameter int MAX_SLOTS  = 16,
    parameter int COORD_BITS = 10
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // slot, pos_x, pos_y, rect_width, rect_height
    input  logic [((4 + 4*COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // cmd
    input  logic [tbht_pkg::CMD_W-1:0]             s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // result_slot
    output logic [tbht_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    // status
    output logic                                   m_axis_tuser
);
    import tbht_pkg::*;

    localparam int X_LSB = SLOT_W;
    localparam int Y_LSB = SLOT_W + COORD_BITS;
    localparam int W_LSB = SLOT_W + 2*COORD_BITS;
    localparam int H_LSB = SLOT_W + 3*COORD_BITS;

    ctrl_cmd_t         cmd;
    ctrl_stat_t        stat;
    logic [SLOT_W-1:0] m_slot;

    tbht_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    tbht_dp #(
        .MAX_SLOTS  (MAX_SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_cmd   (s_axis_tuser),
        .in_slot  (s_axis_tdata[SLOT_W-1:0]),
        .in_x     (s_axis_tdata[X_LSB +: COORD_BITS]),
        .in_y     (s_axis_tdata[Y_LSB +: COORD_BITS]),
        .in_w     (s_axis_tdata[W_LSB +: COORD_BITS]),
        .in_h     (s_axis_tdata[H_LSB +: COORD_BITS]),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_status (m_axis_tuser),
        .m_slot   (m_slot)
    );

    assign m_axis_tdata = M_TDATA_W'(m_slot);

endmodule

### rtl/tbht_ctrl.sv
// ----------------------------------------------------------------------------
// tbht_ctrl
// Sequencer: accepts a command, runs it on the datapath, hands off the result.
// ----------------------------------------------------------------------------
module tbht_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  tbht_pkg::ctrl_stat_t stat,
    output tbht_pkg::ctrl_cmd_t  cmd
);
    import tbht_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = stat.is_touch ? ST_SCAN : ST_OUT;
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                cmd.latch_in  = s_axis_tvalid;
            end
            ST_EXEC: begin
                cmd.exec_op    = 1'b1;
                cmd.scan_start = stat.is_touch;
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
            end
            ST_OUT: begin
                cmd.load_out = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/tbht_dp.sv
// ----------------------------------------------------------------------------
// tbht_dp
// Datapath: rectangle memory, used/enabled flags, slot scan and result register.
// ----------------------------------------------------------------------------
module tbht_dp #(
    parameter int MAX_SLOTS  = 16,
    parameter int COORD_BITS = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tbht_pkg::ctrl_cmd_t                cmd,
    output tbht_pkg::ctrl_stat_t               stat,
    input  logic [tbht_pkg::CMD_W-1:0]         in_cmd,
    input  logic [tbht_pkg::SLOT_W-1:0]        in_slot,
    input  logic [COORD_BITS-1:0]              in_x,
    input  logic [COORD_BITS-1:0]              in_y,
    input  logic [COORD_BITS-1:0]              in_w,
    input  logic [COORD_BITS-1:0]              in_h,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_status,
    output logic [tbht_pkg::SLOT_W-1:0]        m_slot
);
    import tbht_pkg::*;

    localparam int IW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SCAN_W = $clog2(MAX_SLOTS + 1);
    localparam int RECT_W = 4 * COORD_BITS;
    localparam int SUM_W  = COORD_BITS + 1;

    // latched transaction
    logic [CMD_W-1:0]      cmd_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg, w_reg, h_reg;

    logic [MAX_SLOTS-1:0]  used_reg, used_next;
    logic [MAX_SLOTS-1:0]  en_reg, en_next;

    logic [RECT_W-1:0]     rect_mem [MAX_SLOTS];
    logic [RECT_W-1:0]     rd_data_reg;
    logic                  mem_we;

    logic [SCAN_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [IW-1:0]         rd_idx_reg;
    logic                  scan_issue;

    logic                  res_status_reg, res_status_next;
    logic [SLOT_W-1:0]     res_slot_reg, res_slot_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_status_reg;
    logic [SLOT_W-1:0]     m_slot_reg;

    logic [IW-1:0]         free_idx;
    logic                  free_found;
    logic                  slot_ok;
    logic [IW-1:0]         slot_idx;

    logic [COORD_BITS-1:0] r_x, r_y, r_w, r_h;
    logic [SUM_W-1:0]      r_right, r_bottom;
    logic                  hit;

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            cmd_reg  <= in_cmd;
            slot_reg <= in_slot;
            x_reg    <= in_x;
            y_reg    <= in_y;
            w_reg    <= in_w;
            h_reg    <= in_h;
        end
    end

    // lowest unused slot
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_idx   = IW'(i);
                free_found = 1'b1;
            end
        end
    end

    assign slot_ok  = (32'(slot_reg) < MAX_SLOTS);
    assign slot_idx = IW'(slot_reg);
    assign mem_we   = cmd.exec_op && (cmd_reg == CMD_ADD) && free_found;

    always_comb begin
        used_next       = used_reg;
        en_next         = en_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        if (cmd.exec_op) begin
            res_status_next = STATUS_OK;
            res_slot_next   = '0;
            case (cmd_reg)
                CMD_ADD: begin
                    if (free_found) begin
                        used_next[free_idx] = 1'b1;
                        en_next[free_idx]   = 1'b1;
                        res_slot_next       = SLOT_W'(free_idx);
                    end else begin
                        res_status_next = STATUS_MISS;
                    end
                end
                CMD_DELETE: begin
                    if (slot_ok) begin
                        used_next[slot_idx] = 1'b0;
                    end
                end
                CMD_ENABLE: begin
                    if (slot_ok) begin
                        en_next[slot_idx] = 1'b1;
                    end
                end
                CMD_DISABLE: begin
                    if (slot_ok) begin
                        en_next[slot_idx] = 1'b0;
                    end
                end
                CMD_DEL_ALL: begin
                    used_next = '0;
                end
                default: begin
                    used_next = used_reg;
                end
            endcase
        end else if (cmd.scan_run && stat.scan_done) begin
            res_status_next = hit ? STATUS_OK : STATUS_MISS;
            res_slot_next   = hit ? SLOT_W'(rd_idx_reg) : '0;
        end
    end

    // rectangle memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            rect_mem[free_idx] <= {h_reg, w_reg, y_reg, x_reg};
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= rect_mem[scan_idx_reg[IW-1:0]];
        rd_idx_reg  <= scan_idx_reg[IW-1:0];
    end

    // scan address sequencing
    assign scan_issue = cmd.scan_run && (scan_idx_reg < SCAN_W'(MAX_SLOTS));

    always_comb begin
        scan_idx_next = scan_idx_reg;
        rd_valid_next = scan_issue;
        if (cmd.scan_start) begin
            scan_idx_next = '0;
        end else if (scan_issue) begin
            scan_idx_next = scan_idx_reg + SCAN_W'(1);
        end
    end

    // hit test on the slot read last cycle
    assign r_x      = rd_data_reg[0 +: COORD_BITS];
    assign r_y      = rd_data_reg[COORD_BITS +: COORD_BITS];
    assign r_w      = rd_data_reg[2*COORD_BITS +: COORD_BITS];
    assign r_h      = rd_data_reg[3*COORD_BITS +: COORD_BITS];
    assign r_right  = {1'b0, r_x} + {1'b0, r_w};
    assign r_bottom = {1'b0, r_y} + {1'b0, r_h};

    assign hit = rd_valid_reg && en_reg[rd_idx_reg]
                 && (x_reg > r_x) && ({1'b0, x_reg} < r_right)
                 && (y_reg > r_y) && ({1'b0, y_reg} < r_bottom);

    assign stat.scan_done = rd_valid_reg && (hit || (rd_idx_reg == IW'(MAX_SLOTS - 1)));
    assign stat.is_touch  = (cmd_reg == CMD_TOUCH);
    assign stat.out_free  = !m_valid_reg || m_ready;

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
        end
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg     <= '0;
            en_reg       <= '0;
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            used_reg     <= used_next;
            en_reg       <= en_next;
            scan_idx_reg <= scan_idx_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;

endmodule

### dv/touch_button_hit_table_checker.sv
// ----------------------------------------------------------------------------
// touch_button_hit_table_checker
// Watches both stream channels of the hit table, keeps its own copy of the
// rectangle table and flags, predicts the reply of every accepted transaction
// and compares each reply, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module touch_button_hit_table_checker
    import tbht_pkg::*;
#(
    parameter int MAX_SLOTS  = 16,
    parameter int COORD_BITS = 10,
    parameter int S_DATA_W   = 48
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_DATA_W-1:0]  s_axis_tdata,
    input  logic [CMD_W-1:0]     s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 m_axis_tuser,
    output int                   fail_count,
    output int                   replies_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] slot;
    } reply_t;

    coord_t               rect_x [MAX_SLOTS];
    coord_t               rect_y [MAX_SLOTS];
    coord_t               rect_w [MAX_SLOTS];
    coord_t               rect_h [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] slot_used;
    logic [MAX_SLOTS-1:0] slot_enabled;
    reply_t               reply_q [$];

    initial begin
        fail_count  = 0;
        replies_due = 0;
    end

    function automatic reply_t apply_command(input logic [CMD_W-1:0] cmd,
                                             input logic [SLOT_W-1:0] slot,
                                             input coord_t px, input coord_t py,
                                             input coord_t pw, input coord_t ph);
        reply_t                r;
        logic [COORD_BITS:0]   right;
        logic [COORD_BITS:0]   bottom;
        logic                  found;
        int                    i;
        r.status = STATUS_OK;
        r.slot   = '0;
        found    = 1'b0;
        case (cmd)
            CMD_ADD: begin
                r.status = STATUS_MISS;
                for (i = 0; i < MAX_SLOTS; i++) begin
                    if (!found && !slot_used[i]) begin
                        rect_x[i]       = px;
                        rect_y[i]       = py;
                        rect_w[i]       = pw;
                        rect_h[i]       = ph;
                        slot_used[i]    = 1'b1;
                        slot_enabled[i] = 1'b1;
                        found           = 1'b1;
                        r.status        = STATUS_OK;
                        r.slot          = SLOT_W'(i);
                    end
                end
            end
            CMD_DELETE: begin
                if (slot < MAX_SLOTS) slot_used[slot] = 1'b0;
            end
            CMD_ENABLE: begin
                if (slot < MAX_SLOTS) slot_enabled[slot] = 1'b1;
            end
            CMD_DISABLE: begin
                if (slot < MAX_SLOTS) slot_enabled[slot] = 1'b0;
            end
            CMD_TOUCH: begin
                r.status = STATUS_MISS;
                for (i = 0; i < MAX_SLOTS; i++) begin
                    // sums at COORD_BITS+1 bits, never wrap
                    right  = {1'b0, rect_x[i]} + {1'b0, rect_w[i]};
                    bottom = {1'b0, rect_y[i]} + {1'b0, rect_h[i]};
                    if (!found && slot_enabled[i] &&
                        {1'b0, px} > {1'b0, rect_x[i]} && {1'b0, px} < right &&
                        {1'b0, py} > {1'b0, rect_y[i]} && {1'b0, py} < bottom) begin
                        found    = 1'b1;
                        r.status = STATUS_OK;
                        r.slot   = SLOT_W'(i);
                    end
                end
            end
            CMD_DEL_ALL: begin
                slot_used = '0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        reply_t got;
        if (!aresetn) begin
            slot_used    = '0;
            slot_enabled = '0;
            reply_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tuser;
                got.slot   = m_axis_tdata[SLOT_W-1:0];
                if (reply_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected reply status=%0d slot=%0d",
                                 $realtime, got.status, got.slot);
                    fail_count++;
                end else begin
                    want = reply_q.pop_front();
                    if (got.status !== want.status) begin
                        if (fail_count < 10)
                            $display("%0t: status mismatch, expected %0d got %0d",
                                     $realtime, want.status, got.status);
                        fail_count++;
                    end
                    if (got.slot !== want.slot) begin
                        if (fail_count < 10)
                            $display("%0t: result_slot mismatch, expected %0d got %0d",
                                     $realtime, want.slot, got.slot);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                reply_q.push_back(apply_command(
                    s_axis_tuser,
                    s_axis_tdata[SLOT_W-1:0],
                    s_axis_tdata[SLOT_W +: COORD_BITS],
                    s_axis_tdata[SLOT_W + COORD_BITS +: COORD_BITS],
                    s_axis_tdata[SLOT_W + 2*COORD_BITS +: COORD_BITS],
                    s_axis_tdata[SLOT_W + 3*COORD_BITS +: COORD_BITS]));
            end
        end
        replies_due = reply_q.size();
    end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives command transactions into the hit table: a directed opening for the
// coordinate extremes, strict edges, wide sums, deleted-but-enabled slots and
// unknown commands, then random traffic with table fills, targeted touches
// and flag changes, under random bursts and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    import tbht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SLOTS    = 16;
    localparam int COORD_BITS   = 10;
    localparam int S_DATA_W     = ((4 + 4*COORD_BITS + 7) / 8) * 8;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int RANDOM_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 400;

    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    typedef logic [COORD_BITS-1:0] coord_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata;   // slot, pos_x, pos_y, rect_width, rect_height
    logic [CMD_W-1:0]     s_axis_tuser;   // cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // result_slot
    logic                 m_axis_tuser;   // status

    int fail_count;
    int replies_due;
    int cycle_count;
    int replies_seen;
    int burst_left;

    // stimulus-side view of the table, used to keep touches off unwritten rectangles
    logic [MAX_SLOTS-1:0] shadow_used;
    logic [MAX_SLOTS-1:0] shadow_written;
    coord_t               shadow_x [MAX_SLOTS];
    coord_t               shadow_y [MAX_SLOTS];
    coord_t               shadow_w [MAX_SLOTS];
    coord_t               shadow_h [MAX_SLOTS];

    touch_button_hit_table_core #(
        .MAX_SLOTS (MAX_SLOTS),
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    touch_button_hit_table_checker #(
        .MAX_SLOTS (MAX_SLOTS),
        .COORD_BITS(COORD_BITS),
        .S_DATA_W  (S_DATA_W)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .fail_count   (fail_count),
        .replies_due  (replies_due)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial replies_seen = 0;
    always @(posedge aclk) begin
        if (m_axis_tvalid && m_axis_tready) replies_seen <= replies_seen + 1;
    end

    // receiver: random ready patterns in phases, one long hold-off
    initial begin
        int   phase_left;
        int   mode;
        logic held;
        m_axis_tready = 1'b0;
        phase_left    = 0;
        mode          = 0;
        held          = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && replies_seen >= 400) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            if (phase_left == 0) begin
                mode       = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 150);
            end
            phase_left--;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 4) == 0);
                default: m_axis_tready <= ~m_axis_tready;
            endcase
        end
    end

    task automatic track_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                                 input coord_t x, input coord_t y,
                                 input coord_t w, input coord_t h);
        int   i;
        logic placed;
        placed = 1'b0;
        case (cmd)
            CMD_ADD: begin
                for (i = 0; i < MAX_SLOTS; i++) begin
                    if (!placed && !shadow_used[i]) begin
                        placed            = 1'b1;
                        shadow_used[i]    = 1'b1;
                        shadow_written[i] = 1'b1;
                        shadow_x[i]       = x;
                        shadow_y[i]       = y;
                        shadow_w[i]       = w;
                        shadow_h[i]       = h;
                    end
                end
            end
            CMD_DELETE:  shadow_used[slot] = 1'b0;
            CMD_DEL_ALL: shadow_used = '0;
            default: begin
            end
        endcase
    endtask

    // one transaction on the input channel, called at a falling edge
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                                input coord_t x, input coord_t y,
                                input coord_t w, input coord_t h);
        logic [S_DATA_W-1:0] word;
        word = '0;
        word[SLOT_W-1:0]                           = slot;
        word[SLOT_W +: COORD_BITS]                 = x;
        word[SLOT_W + COORD_BITS +: COORD_BITS]    = y;
        word[SLOT_W + 2*COORD_BITS +: COORD_BITS]  = w;
        word[SLOT_W + 3*COORD_BITS +: COORD_BITS]  = h;
        track_command(cmd, slot, x, y, w, h);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= cmd;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random_command();
        int                 pick;
        int                 k;
        int                 x_hi;
        int                 y_hi;
        logic [CMD_W-1:0]   cmd;
        logic [SLOT_W-1:0]  slot;
        coord_t             x;
        coord_t             y;
        coord_t             w;
        coord_t             h;
        slot = SLOT_W'($urandom);
        x    = coord_t'($urandom);
        y    = coord_t'($urandom);
        w    = coord_t'($urandom);
        h    = coord_t'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            cmd = CMD_ADD;
            if ($urandom_range(0, 7) != 0) begin
                w = coord_t'($urandom_range(0, 160));
                h = coord_t'($urandom_range(0, 160));
            end
        end else if (pick < 63) begin
            cmd = CMD_TOUCH;
            if (shadow_written != '0 && $urandom_range(0, 3) != 0) begin
                do k = $urandom_range(0, MAX_SLOTS - 1); while (!shadow_written[k]);
                x_hi = int'(shadow_x[k]) + int'(shadow_w[k]);
                y_hi = int'(shadow_y[k]) + int'(shadow_h[k]);
                if (x_hi > COORD_MAX) x_hi = COORD_MAX;
                if (y_hi > COORD_MAX) y_hi = COORD_MAX;
                x = coord_t'($urandom_range(int'(shadow_x[k]), x_hi));
                y = coord_t'($urandom_range(int'(shadow_y[k]), y_hi));
            end
        end else if (pick < 73) begin
            cmd = CMD_DISABLE;
            if (shadow_written != '0) begin
                cmd = CMD_ENABLE;
                do k = $urandom_range(0, MAX_SLOTS - 1); while (!shadow_written[k]);
                slot = SLOT_W'(k);
            end
        end else if (pick < 83) begin
            cmd = CMD_DISABLE;
        end else if (pick < 93) begin
            cmd = CMD_DELETE;
        end else if (pick < 96) begin
            cmd = CMD_DEL_ALL;
        end else begin
            cmd = $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
        end
        send_command(cmd, slot, x, y, w, h);
    endtask

    initial begin
        int n;
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = CMD_ADD;
        shadow_used    = '0;
        shadow_written = '0;
        burst_left     = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_command(CMD_ADD,     4'hF, 10'd0,    10'd0,    10'd1023, 10'd1023);
        send_command(CMD_ADD,     4'h0, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_command(CMD_ADD,     4'h5, 10'd1000, 10'd1000, 10'd100,  10'd100);
        send_command(CMD_TOUCH,   4'h0, 10'd1,    10'd1,    10'd0,    10'd0);
        send_command(CMD_TOUCH,   4'hF, 10'd0,    10'd0,    10'd1023, 10'd1023);
        // slot 0 edge is exclusive, wide rectangle past 1023 catches it
        send_command(CMD_TOUCH,   4'h0, 10'd1023, 10'd1023, 10'd0,    10'd0);
        send_command(CMD_DISABLE, 4'h0, 10'd0,    10'd0,    10'd0,    10'd0);
        send_command(CMD_TOUCH,   4'h0, 10'd1,    10'd1,    10'd0,    10'd0);
        send_command(CMD_DELETE,  4'h0, 10'd0,    10'd0,    10'd0,    10'd0);
        send_command(CMD_ENABLE,  4'h0, 10'd0,    10'd0,    10'd0,    10'd0);
        // deleted yet enabled: still a hit
        send_command(CMD_TOUCH,   4'h0, 10'd1,    10'd1,    10'd0,    10'd0);
        send_command(CMD_DISABLE, 4'hF, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_command(CMD_DELETE,  4'hF, 10'd0,    10'd0,    10'd0,    10'd0);
        send_command(CMD_RSVD_6,  4'hF, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_command(CMD_RSVD_7,  4'h0, 10'd0,    10'd0,    10'd0,    10'd0);
        send_command(CMD_DEL_ALL, 4'hA, 10'd512,  10'd512,  10'd512,  10'd512);
        send_command(CMD_ADD,     4'h0, 10'd0,    10'd0,    10'd0,    10'd0);
        send_command(CMD_TOUCH,   4'h0, 10'd0,    10'd0,    10'd0,    10'd0);

        for (n = 0; n < RANDOM_ITEMS; n++) send_random_command();

        s_axis_tvalid <= 1'b0;
        while (replies_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && replies_due == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
